// File: design/plas_pkg.sv
package plas_pkg;

  localparam int WINDOW = 8;
  localparam int LEN_W  = 16;
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = LEN_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } plas_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } plas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } plas_sts_t;

endpackage

// File: design/plas_ctrl.sv
module plas_ctrl
  import plas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  plas_sts_t sts,
  output plas_cmd_t cmd
);

  plas_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/plas_dp.sv
module plas_dp
  import plas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  plas_cmd_t        cmd,
  output plas_sts_t        sts,
  input  logic [LEN_W-1:0] in_packet_length,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_min_length,
  output logic             out_below_minimum,
  output logic [LEN_W-1:0] out_average_length
);

  logic [LEN_W-1:0]  win_r [WINDOW];
  logic [PTR_W-1:0]  ptr_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  min_r;

  // divider: dividend bits shift out of the top, quotient bits shift in at the bottom
  logic [SUM_W-1:0]  dq_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;

  logic [LEN_W-1:0]  avg_r;
  logic              below_r;

  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [PTR_W-1:0]  ptr_new;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              ge;

  always_comb begin
    sum_new = sum_r - SUM_W'(win_r[ptr_r]) + SUM_W'(in_packet_length);
    cnt_new = (cnt_r == CNT_W'(WINDOW)) ? cnt_r : cnt_r + CNT_W'(1);
    ptr_new = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
    rem_sh   = {rem_r, dq_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, cnt_r};
    ge       = rem_sh >= {1'b0, cnt_r};
  end

  assign sts.div_last = (step_r == STEP_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      ptr_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
      min_r <= '0;
    end else begin
      if (cfg_we) begin
        min_r <= cfg_min_length;
      end
      if (cmd.load) begin
        win_r[ptr_r] <= in_packet_length;
        ptr_r        <= ptr_new;
        sum_r        <= sum_new;
        cnt_r        <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq_r   <= sum_new;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.step) begin
      rem_r  <= ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dq_r   <= {dq_r[SUM_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.out_load) begin
      avg_r   <= dq_r[LEN_W-1:0];
      below_r <= dq_r[LEN_W-1:0] < min_r;
    end
  end

  assign out_average_length = avg_r;
  assign out_below_minimum  = below_r;

endmodule

// File: design/packet_length_average_splitter_top.sv
// Packet length average splitter: each input word is a packet length; the block keeps the
// last WINDOW lengths, their running sum and a fill count that stops at WINDOW, and returns
// one result word per packet with the truncated average (sum over fill count) and a flag
// set when that average is below min_length. For each packet the window is updated, the
// bit-serial divider works out the quotient of the SUM_W-bit sum one bit at a time, and
// the output register is loaded. A new packet is taken while the previous result still
// waits in the output register. min_length is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module packet_length_average_splitter_top
  import plas_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [LEN_W-1:0] in_packet_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_below_minimum,
  output logic [LEN_W-1:0] out_average_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_min_length
);

  plas_cmd_t cmd;
  plas_sts_t sts;

  assign cfg_ready = 1'b1;

  plas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plas_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_packet_length   (in_packet_length),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_min_length     (cfg_min_length),
    .out_below_minimum  (out_below_minimum),
    .out_average_length (out_average_length)
  );

endmodule

// File: design/plas_checker.sv
module plas_checker
  import plas_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_below_minimum,
  input logic [LEN_W-1:0] out_average_length
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average_length)
      && $stable(out_below_minimum))
    else $error("stalled result word changed");

  // one packet in flight: no second word right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

  // a result only appears after the divider has finished, while input is held off
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // leaving reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind packet_length_average_splitter_top plas_checker u_plas_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_below_minimum  (out_below_minimum),
  .out_average_length (out_average_length)
);

// File: verif/packet_length_average_splitter_top_tb.sv
module packet_length_average_splitter_top_tb;
  import plas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic             below;
    logic [LEN_W-1:0] average;
  } avg_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [LEN_W-1:0] in_packet_length = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_below_minimum;
  logic [LEN_W-1:0] out_average_length;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_min_length = '0;

  // predictor state
  logic [LEN_W-1:0] win_len [WINDOW];
  int unsigned      win_sum;
  int unsigned      win_fill;
  int unsigned      win_pos;
  logic [LEN_W-1:0] min_len;

  logic [LEN_W-1:0] pending_lengths [$];
  avg_result_t      expected_averages [$];

  bit          in_idle_on = 1'b0;
  bit          out_idle_on = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  packet_length_average_splitter_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_packet_length   (in_packet_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_below_minimum  (out_below_minimum),
    .out_average_length (out_average_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_min_length     (cfg_min_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic avg_result_t predict_average(input logic [LEN_W-1:0] len);
    int unsigned quot;
    avg_result_t res;
    win_sum = win_sum - win_len[win_pos] + len;
    win_len[win_pos] = len;
    win_pos = (win_pos + 1) % WINDOW;
    if (win_fill < WINDOW) win_fill = win_fill + 1;
    quot = win_sum / win_fill;
    if (quot > 32'hFFFF) quot = 32'hFFFF;
    res.average = quot[LEN_W-1:0];
    res.below = (res.average < min_len);
    return res;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 15);
      2: v = 65535 - $urandom_range(0, 15);
      // lengths near the threshold so the flag flips often
      3: v = int'(min_len) + int'($urandom_range(0, 64)) - 32;
      4: v = $urandom_range(40, 1500);
      default: v = 1 << $urandom_range(0, 15);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[LEN_W-1:0];
  endfunction

  task automatic write_min_length(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_min_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_len = value;
  endtask

  task automatic wait_drained();
    while (pending_lengths.size() != 0 || in_valid || expected_averages.size() != 0)
      @(negedge clk);
    repeat (2 * (SUM_W + 2)) @(posedge clk);
    @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_averages.push_back(predict_average(in_packet_length));
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_lengths.size() != 0) begin
          in_packet_length <= pending_lengths.pop_front();
          in_valid <= 1'b1;
          if (in_idle_on && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with stall bursts and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_idle_on && $urandom_range(0, 4) == 0) recv_gap <= $urandom_range(1, 14);
    end
  end

  // result checker
  always @(posedge clk) begin
    avg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result word: below=%0d average=%0d",
                   out_below_minimum, out_average_length);
      end else begin
        want = expected_averages.pop_front();
        if (out_below_minimum !== want.below || out_average_length !== want.average) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: below exp %0d got %0d, average exp %0d got %0d",
                     want.below, out_below_minimum, want.average, out_average_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("packet_length_average_splitter_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [LEN_W-1:0] phase_min [PHASES];
    for (int i = 0; i < WINDOW; i++) win_len[i] = '0;
    win_sum = 0;
    win_fill = 0;
    win_pos = 0;
    min_len = '0;
    phase_min[0] = 16'h0000;
    phase_min[1] = 16'hFFFF;
    phase_min[2] = LEN_W'($urandom_range(0, 65535));
    phase_min[3] = 16'd1500;
    phase_min[4] = 16'h0001;
    phase_min[5] = LEN_W'($urandom_range(0, 65535));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: window filling up, full-scale lengths, bit patterns
    write_min_length(16'h8000);
    @(negedge clk);
    for (int i = 0; i < 9; i++) pending_lengths.push_back(16'hFFFF);
    pending_lengths.push_back(16'h0000);
    pending_lengths.push_back(16'h0000);
    pending_lengths.push_back(16'h8000);
    pending_lengths.push_back(16'h7FFF);
    pending_lengths.push_back(16'h5555);
    pending_lengths.push_back(16'hAAAA);
    pending_lengths.push_back(16'h0001);
    pending_lengths.push_back(16'h00FF);
    pending_lengths.push_back(16'hFF00);
    for (int i = 0; i < 6; i++) pending_lengths.push_back(16'h0000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_min_length(phase_min[p]);
      @(negedge clk);
      in_idle_on = (p < PHASES - 1) && (p != 2);
      out_idle_on = (p < PHASES - 1);
      if (p == 2) begin
        // back up the block: sender keeps going while the receiver holds off
        holds_asked = holds_asked + 1;
        for (int i = 0; i < PHASE_ITEMS; i++) pending_lengths.push_back(random_length());
      end else if (p == 3) begin
        for (int i = 0; i < PHASE_ITEMS / 2; i++) pending_lengths.push_back(random_length());
        // sender pauses until every result is back
        wait_drained();
        for (int i = 0; i < PHASE_ITEMS / 2; i++) pending_lengths.push_back(random_length());
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) pending_lengths.push_back(random_length());
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_averages.size() == 0) begin
      $display("packet_length_average_splitter_top_tb OK");
    end else begin
      $display("packet_length_average_splitter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
